FILE: src/rgbhsv_pkg.sv
// shared types, widths and constants of the rgb to hsv converter
package rgbhsv_pkg;

	localparam int CH_W       = 8;
	localparam int HUE_W      = 15;
	localparam int SAT_W      = 13;
	localparam int NUM_W      = 20;
	localparam int Q_W        = 20;
	localparam int RECIP_SH   = 20;
	localparam int RECIP_W    = RECIP_SH + 1;
	localparam int DIV_LAT    = 4;
	localparam int PIPE_DEPTH = DIV_LAT + 3;
	localparam int S_DATA_W   = 24;
	localparam int M_DATA_W   = 40;

	localparam logic [HUE_W-1:0] HUE_SECTOR = 15'd7680;
	localparam logic [HUE_W-1:0] HUE_SECTOR2 = 15'd15360;
	localparam logic [11:0]      HUE_HALF   = 12'd3840;
	localparam logic [HUE_W:0]   HUE_FULL   = 16'd23040;
	localparam int               SAT_SH     = 12;

	typedef struct packed {
		logic [HUE_W-1:0] sector;
		logic             neg;
		logic             gray;
		logic [CH_W-1:0]  mx;
	} side_t;

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [CH_W-1:0]  den;
	} div_req_t;

	typedef struct packed {
		logic [Q_W-1:0] q;
		logic           rnz;
	} div_res_t;

endpackage

FILE: src/rgbhsv_front.sv
// max, min, chroma and divider operand stages of the rgb to hsv converter
module rgbhsv_front
	import rgbhsv_pkg::*;
(
	input  logic            clk,
	input  logic            en,
	input  logic [CH_W-1:0] red,
	input  logic [CH_W-1:0] green,
	input  logic [CH_W-1:0] blue,
	output side_t           side,
	output div_req_t        hue_req,
	output div_req_t        sat_req
);

	logic [CH_W-1:0]  mx, mn, chroma;
	logic [CH_W:0]    d;
	logic [HUE_W-1:0] sector;

	logic [CH_W-1:0]  mx_s1, chroma_s1, mag_s1;
	logic [HUE_W-1:0] sector_s1;
	logic             neg_s1;

	side_t    side_s2;
	div_req_t hue_req_s2, sat_req_s2;

	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		chroma = mx - mn;
		priority if (mx == red) begin
			d = {1'b0, green} - {1'b0, blue};
			sector = '0;
		end else if (mx == green) begin
			d = {1'b0, blue} - {1'b0, red};
			sector = HUE_SECTOR;
		end else begin
			d = {1'b0, red} - {1'b0, green};
			sector = HUE_SECTOR2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1     <= mx;
			chroma_s1 <= chroma;
			sector_s1 <= sector;
			neg_s1    <= d[CH_W];
			mag_s1    <= d[CH_W] ? CH_W'(-d) : d[CH_W-1:0];

			side_s2.sector <= sector_s1;
			side_s2.neg    <= neg_s1;
			side_s2.gray   <= (chroma_s1 == '0);
			side_s2.mx     <= mx_s1;
			hue_req_s2.num <= {{(NUM_W-CH_W){1'b0}}, mag_s1} *
				{{(NUM_W-12){1'b0}}, HUE_HALF};
			hue_req_s2.den <= chroma_s1;
			sat_req_s2.num <= NUM_W'({chroma_s1, {SAT_SH{1'b0}}});
			sat_req_s2.den <= mx_s1;
		end
	end

	assign side    = side_s2;
	assign hue_req = hue_req_s2;
	assign sat_req = sat_req_s2;

endmodule

FILE: src/rgbhsv_div.sv
// pipelined reciprocal divider: table lookup, multiply, back-multiply, correct
module rgbhsv_div
	import rgbhsv_pkg::*;
(
	input  logic     clk,
	input  logic     en,
	input  div_req_t req,
	output div_res_t res
);

	logic [RECIP_W-1:0] recip_tab [2**CH_W];

	for (genvar i = 0; i < 2**CH_W; i++) begin : g_recip
		localparam int RV = (i == 0) ? 0 : ((2**RECIP_SH) / ((i == 0) ? 1 : i) + 1);
		assign recip_tab[i] = RECIP_W'(RV);
	end

	logic [NUM_W-1:0]         num_s1, num_s2, num_s3;
	logic [CH_W-1:0]          den_s1, den_s2, den_s3;
	logic [RECIP_W-1:0]       recip_s1;
	logic [Q_W-1:0]           q_s2, q_s3;
	logic [Q_W+CH_W-1:0]      qc_s3;
	div_res_t                 res_s4;

	logic [NUM_W+RECIP_W-1:0] prod;
	logic [Q_W+CH_W-1:0]      num_ext, rem;
	logic                     over;

	assign prod    = {{RECIP_W{1'b0}}, num_s1} * {{NUM_W{1'b0}}, recip_s1};
	assign num_ext = (Q_W+CH_W)'(num_s3);
	assign over    = qc_s3 > num_ext;
	assign rem     = over ? num_ext + (Q_W+CH_W)'(den_s3) - qc_s3 : num_ext - qc_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1   <= req.num;
			den_s1   <= req.den;
			recip_s1 <= recip_tab[req.den];

			num_s2 <= num_s1;
			den_s2 <= den_s1;
			q_s2   <= prod[RECIP_SH+Q_W-1:RECIP_SH];

			num_s3 <= num_s2;
			den_s3 <= den_s2;
			q_s3   <= q_s2;
			qc_s3  <= {{CH_W{1'b0}}, q_s2} * {{Q_W{1'b0}}, den_s2};

			res_s4.q   <= over ? q_s3 - 1'b1 : q_s3;
			res_s4.rnz <= (rem != '0);
		end
	end

	assign res = res_s4;

endmodule

FILE: src/rgb_to_hsv_converter.sv
// top level: rgb pixel stream in, hsv pixel stream out
// an accepted input beat passes the front stages, the divider stages and the output register to its output beat
// throughput: one beat per cycle while the output is not stalled, set by the fully pipelined reciprocal dividers
// a stalled output holds the whole pipeline; no beat is lost or repeated
// reset clears only the stage valid bits; data registers are not reset
module rgb_to_hsv_converter
	import rgbhsv_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata    // hue[14:0], saturation[27:15], brightness[35:28]
);

	logic                  en;
	logic [PIPE_DEPTH-1:0] vld_s;
	side_t                 side;
	side_t                 side_s [DIV_LAT];
	div_req_t              hue_req, sat_req;
	div_res_t              hue_res, sat_res;

	logic [HUE_W-1:0]      hue_s7;
	logic [SAT_W-1:0]      sat_s7;
	logic [CH_W-1:0]       bright_s7;

	logic [HUE_W+1:0]      hsec, hpart, hsum, hwrap;
	logic [HUE_W-1:0]      hue_nx;
	logic [SAT_W-1:0]      sat_nx;
	side_t                 sd;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_s[PIPE_DEPTH-1];

	rgbhsv_front u_front (
		.clk     (clk),
		.en      (en),
		.red     (s_tdata[7:0]),
		.green   (s_tdata[15:8]),
		.blue    (s_tdata[23:16]),
		.side    (side),
		.hue_req (hue_req),
		.sat_req (sat_req)
	);

	rgbhsv_div u_hue_div (
		.clk (clk),
		.en  (en),
		.req (hue_req),
		.res (hue_res)
	);

	rgbhsv_div u_sat_div (
		.clk (clk),
		.en  (en),
		.req (sat_req),
		.res (sat_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[PIPE_DEPTH-2:0], s_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side;
			for (int i = 1; i < DIV_LAT; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	always_comb begin
		sd    = side_s[DIV_LAT-1];
		hsec  = (HUE_W+2)'(sd.sector);
		hpart = (HUE_W+2)'(hue_res.q[11:0]);
		if (sd.neg) begin
			hsum = hsec - hpart - (HUE_W+2)'(hue_res.rnz);
		end else begin
			hsum = hsec + hpart;
		end
		hwrap  = hsum[HUE_W+1] ? hsum + (HUE_W+2)'(HUE_FULL) : hsum;
		hue_nx = sd.gray ? '0 : hwrap[HUE_W-1:0];
		sat_nx = (sd.mx == '0) ? '0 : sat_res.q[SAT_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_s7    <= hue_nx;
			sat_s7    <= sat_nx;
			bright_s7 <= sd.mx;
		end
	end

	assign m_tdata = {{(M_DATA_W-HUE_W-SAT_W-CH_W){1'b0}}, bright_s7, sat_s7, hue_s7};

endmodule

FILE: tb/sv/tb_top.sv
// testbench for the rgb to hsv converter: directed and random pixels checked beat by beat
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rgbhsv_pkg::*;

	localparam int SECTOR   = 7680;
	localparam int HALF_SEC = 3840;
	localparam int FULL_HUE = 23040;
	localparam int SAT_ONE  = 4096;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [SAT_W-1:0] sat;
		logic [CH_W-1:0]  val;
	} hsv_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;

	hsv_t pending_hsv[$];
	int   errors;
	int   src_idle_pct;
	int   sink_stall_pct;
	int   sink_hold_left;

	rgb_to_hsv_converter u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

	function automatic hsv_t hsv_of(input logic [CH_W-1:0] r, g, b);
		int   ri, gi, bi, mx, mn, c, d, base, mag, q, h;
		hsv_t res;
		ri = int'(r);
		gi = int'(g);
		bi = int'(b);
		mx = ri;
		mn = ri;
		if (gi > mx) mx = gi;
		if (bi > mx) mx = bi;
		if (gi < mn) mn = gi;
		if (bi < mn) mn = bi;
		c = mx - mn;
		if (c == 0) begin
			h = 0;
		end else begin
			if (mx == ri) begin
				d = gi - bi;
				base = 0;
			end else if (mx == gi) begin
				d = bi - ri;
				base = SECTOR;
			end else begin
				d = ri - gi;
				base = 2 * SECTOR;
			end
			mag = (d < 0 ? -d : d) * HALF_SEC;
			q = mag / c;
			// floor toward minus infinity for a negative difference
			if (d < 0 && (mag % c) != 0) q = q + 1;
			h = base + (d < 0 ? -q : q);
		end
		if (h < 0) h = h + FULL_HUE;
		res.hue = h[HUE_W-1:0];
		res.sat = (mx == 0) ? '0 : SAT_W'((c * SAT_ONE) / mx);
		res.val = mx[CH_W-1:0];
		return res;
	endfunction

	task automatic send_pixel(input logic [CH_W-1:0] r, g, b);
		while ($urandom_range(99) < src_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {b, g, r};
		do @(posedge clk); while (!s_tready);
		pending_hsv.push_back(hsv_of(r, g, b));
	endtask

	task automatic send_random_pixel();
		logic [CH_W-1:0] r, g, b, v;
		int              kind;
		kind = $urandom_range(9);
		r = CH_W'($urandom);
		g = CH_W'($urandom);
		b = CH_W'($urandom);
		v = CH_W'($urandom);
		case (kind)
			0: begin
				r = v;
				g = v;
				b = v;
			end
			1: begin
				// two channels tied at the maximum
				case ($urandom_range(2))
					0: begin r = v; g = v; b = CH_W'($urandom_range(v)); end
					1: begin g = v; b = v; r = CH_W'($urandom_range(v)); end
					default: begin r = v; b = v; g = CH_W'($urandom_range(v)); end
				endcase
			end
			2: begin
				r = CH_W'($urandom_range(3));
				g = CH_W'($urandom_range(3));
				b = CH_W'($urandom_range(3));
			end
			3: begin
				r = CH_W'($urandom_range(1) ? 255 - $urandom_range(1) : $urandom_range(1));
				g = CH_W'($urandom_range(1) ? 255 - $urandom_range(1) : $urandom_range(1));
				b = CH_W'($urandom_range(1) ? 255 - $urandom_range(1) : $urandom_range(1));
			end
			4: begin
				// red maximum with blue above green wraps the hue
				r = CH_W'($urandom_range(255, 2));
				g = CH_W'($urandom_range(r - 2));
				b = CH_W'($urandom_range(r - 1, g + 1));
			end
			default: ;
		endcase
		send_pixel(r, g, b);
	endtask

	task automatic test_directed();
		logic [S_DATA_W-1:0] pix[$] = '{
			24'h000000, 24'hFFFFFF, 24'h808080, 24'h0000FF, 24'h00FF00,
			24'hFF0000, 24'h00FFFF, 24'hFFFF00, 24'hFF00FF, 24'h0001FF,
			24'h0100FF, 24'h000001, 24'h000100, 24'h010000, 24'h640AC8,
			24'hFE00FF, 24'h00FFFE, 24'h64C80A, 24'hC80A64, 24'h000101,
			24'h010100, 24'h010001, 24'hFFAA55, 24'hFCFDFE, 24'hFFFEFF
		};
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		foreach (pix[i])
			send_pixel(pix[i][7:0], pix[i][15:8], pix[i][23:16]);
	endtask

	task automatic test_random(input int idle_pct, input int stall_pct, input int count);
		src_idle_pct   = idle_pct;
		sink_stall_pct = stall_pct;
		repeat (count) send_random_pixel();
	endtask

	task automatic test_backpressure();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		sink_hold_left = 300;
		repeat (60) send_random_pixel();
	endtask

	always @(negedge clk) begin
		if (sink_hold_left > 0) begin
			m_tready <= 1'b0;
			sink_hold_left = sink_hold_left - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		hsv_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.hue = m_tdata[14:0];
			got.sat = m_tdata[27:15];
			got.val = m_tdata[35:28];
			if (pending_hsv.size() == 0) begin
				$display("%0t: unexpected beat hue %0d sat %0d val %0d",
					$time, got.hue, got.sat, got.val);
				errors++;
			end else begin
				want = pending_hsv.pop_front();
				if (got.hue !== want.hue) begin
					$display("%0t: hue expected %0d actual %0d", $time, want.hue, got.hue);
					errors++;
				end
				if (got.sat !== want.sat) begin
					$display("%0t: saturation expected %0d actual %0d",
						$time, want.sat, got.sat);
					errors++;
				end
				if (got.val !== want.val) begin
					$display("%0t: brightness expected %0d actual %0d",
						$time, want.val, got.val);
					errors++;
				end
			end
		end
	end

	initial begin
		errors         = 0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		sink_hold_left = 0;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		m_tready       = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random(0, 0, 380);
		test_random(69, 0, 380);
		test_random(0, 69, 380);
		test_random(30, 30, 380);
		test_backpressure();

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending_hsv.size() == 0);
		repeat (4 * PIPE_DEPTH) @(posedge clk);
		if (errors == 0 && pending_hsv.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
